// ===== rtl/shot_detect_heat_estimator_top_macros.svh =====
// Assertion macros for the shot detect / heat estimator block.
// Used by the top level only; no other dependencies.
`ifndef SHOT_DETECT_HEAT_ESTIMATOR_TOP_MACROS_SVH
`define SHOT_DETECT_HEAT_ESTIMATOR_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define SHD_ASSERT(label, prop) label: assert property (@(posedge clk) disable iff (rst) prop) \
  else $error("shd assertion failed");
`define SHD_ASSERT_RST(label, prop) label: assert property (@(posedge clk) prop) \
  else $error("shd reset assertion failed");
`else
`define SHD_ASSERT(label, prop)
`define SHD_ASSERT_RST(label, prop)
`endif
`endif

// ===== rtl/shd_pkg.sv =====
// Shared types, constants and register map of the shot detect / heat estimator.
// No dependencies.
package shd_pkg;

  localparam int CFG_W          = 16;
  localparam int HPS_W          = 20;
  localparam int TIME_W         = 32;
  localparam int CUR_W          = 16;
  localparam int HP_W           = 16;
  localparam int COOL_W         = 16;
  localparam int DROP_W         = TIME_W + COOL_W;
  localparam int OUT_HEAT_W     = 24;
  localparam int HEAT_WIDTH_DEF = 24;
  localparam int PADDR_W        = 5;
  localparam int PDATA_W        = 32;

  localparam logic [2:0] REG_WINDOW_HIGH   = 3'd0;
  localparam logic [2:0] REG_WINDOW_LOW    = 3'd1;
  localparam logic [2:0] REG_FALL_LEVEL    = 3'd2;
  localparam logic [2:0] REG_HOLD_MS       = 3'd3;
  localparam logic [2:0] REG_GIVE_UP_MS    = 3'd4;
  localparam logic [2:0] REG_HEAT_PER_SHOT = 3'd5;

  localparam logic [CFG_W-1:0] RST_WINDOW_HIGH   = 16'd5500;
  localparam logic [CFG_W-1:0] RST_WINDOW_LOW    = 16'd1500;
  localparam logic [CFG_W-1:0] RST_FALL_LEVEL    = 16'd1000;
  localparam logic [CFG_W-1:0] RST_HOLD_MS       = 16'd5;
  localparam logic [CFG_W-1:0] RST_GIVE_UP_MS    = 16'd50;
  localparam logic [HPS_W-1:0] RST_HEAT_PER_SHOT = 20'd10000;

  typedef enum logic [1:0] {
    PH_READY   = 2'd0,
    PH_SUSPECT = 2'd1,
    PH_WAIT    = 2'd2,
    PH_DONE    = 2'd3
  } phase_t;

  typedef struct packed {
    logic [CFG_W-1:0] window_high;
    logic [CFG_W-1:0] window_low;
    logic [CFG_W-1:0] fall_level;
    logic [CFG_W-1:0] hold_ms;
    logic [CFG_W-1:0] give_up_ms;
    logic [HPS_W-1:0] heat_per_shot;
  } cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0]        time_ms;
    logic signed [CUR_W-1:0]  wheel_current;
    logic                     wheel_ready;
    logic [HP_W-1:0]          robot_hp;
    logic [COOL_W-1:0]        cooling_rate;
    logic                     force_ready;
  } in_item_t;

  typedef struct packed {
    logic [OUT_HEAT_W-1:0] heat;
    logic                  shot_counted;
    logic [1:0]            detect_phase;
  } out_item_t;

endpackage

// ===== rtl/shd_cfg_regs.sv =====
// APB-style configuration registers of the shot detect / heat estimator.
// Depends on shd_pkg.
module shd_cfg_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [shd_pkg::PADDR_W-1:0]  paddr,
  input  logic [shd_pkg::PDATA_W-1:0]  pwdata,
  output logic [shd_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output shd_pkg::cfg_t                cfg
);
  import shd_pkg::*;

  logic [2:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[PADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_high   <= RST_WINDOW_HIGH;
      cfg.window_low    <= RST_WINDOW_LOW;
      cfg.fall_level    <= RST_FALL_LEVEL;
      cfg.hold_ms       <= RST_HOLD_MS;
      cfg.give_up_ms    <= RST_GIVE_UP_MS;
      cfg.heat_per_shot <= RST_HEAT_PER_SHOT;
    end else if (wr_en) begin
      case (reg_idx)
        REG_WINDOW_HIGH:   cfg.window_high   <= pwdata[CFG_W-1:0];
        REG_WINDOW_LOW:    cfg.window_low    <= pwdata[CFG_W-1:0];
        REG_FALL_LEVEL:    cfg.fall_level    <= pwdata[CFG_W-1:0];
        REG_HOLD_MS:       cfg.hold_ms       <= pwdata[CFG_W-1:0];
        REG_GIVE_UP_MS:    cfg.give_up_ms    <= pwdata[CFG_W-1:0];
        REG_HEAT_PER_SHOT: cfg.heat_per_shot <= pwdata[HPS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_WINDOW_HIGH:   prdata = {{(PDATA_W-CFG_W){1'b0}}, cfg.window_high};
      REG_WINDOW_LOW:    prdata = {{(PDATA_W-CFG_W){1'b0}}, cfg.window_low};
      REG_FALL_LEVEL:    prdata = {{(PDATA_W-CFG_W){1'b0}}, cfg.fall_level};
      REG_HOLD_MS:       prdata = {{(PDATA_W-CFG_W){1'b0}}, cfg.hold_ms};
      REG_GIVE_UP_MS:    prdata = {{(PDATA_W-CFG_W){1'b0}}, cfg.give_up_ms};
      REG_HEAT_PER_SHOT: prdata = {{(PDATA_W-HPS_W){1'b0}}, cfg.heat_per_shot};
      default:           prdata = '0;
    endcase
  end

endmodule

// ===== rtl/shd_track.sv =====
// Shot detector state machine and heat accumulator, one item per enable.
// Depends on shd_pkg; the cooling drop arrives precomputed.
module shd_track #(
  parameter int HEAT_WIDTH = shd_pkg::HEAT_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  shd_pkg::cfg_t               cfg,
  input  shd_pkg::in_item_t           item,
  input  logic [shd_pkg::DROP_W-1:0]  drop,
  output shd_pkg::out_item_t          res
);
  import shd_pkg::*;

  localparam int ACC_W = ((HEAT_WIDTH > HPS_W) ? HEAT_WIDTH : HPS_W) + 1;
  localparam int CMP_W = ((HEAT_WIDTH > DROP_W) ? HEAT_WIDTH : DROP_W) + 1;
  localparam logic [HEAT_WIDTH-1:0] HEAT_MAX = '1;

  phase_t                phase, phase_next;
  logic [TIME_W-1:0]     suspect_start, suspect_start_next;
  logic [HEAT_WIDTH-1:0] heat_acc, heat_acc_next;
  logic                  hp_was_nonzero;

  logic signed [CUR_W+1:0] cur;
  logic                    in_win, below_fall, rebirth, shot;
  logic [TIME_W-1:0]       elapsed;
  logic [ACC_W-1:0]        sum;
  logic [HEAT_WIDTH-1:0]   base;
  logic [CMP_W-1:0]        base_ext, drop_ext, heat_ext;

  // current is negated; 18 bits hold -32767..32768 and unsigned 16-bit limits
  assign cur = -{{2{item.wheel_current[CUR_W-1]}}, item.wheel_current};
  assign in_win = (cur < $signed({2'b00, cfg.window_high})) &&
                  (cur > $signed({2'b00, cfg.window_low}));
  assign below_fall = cur < $signed({2'b00, cfg.fall_level});
  assign elapsed    = item.time_ms - suspect_start;
  assign rebirth    = (item.robot_hp != '0) && !hp_was_nonzero;

  // next state
  always_comb begin
    phase_next         = phase;
    suspect_start_next = suspect_start;
    if (rebirth) begin
      phase_next = PH_READY;
    end else begin
      case (phase)
        PH_READY: begin
          if (item.wheel_ready && in_win) begin
            phase_next         = PH_SUSPECT;
            suspect_start_next = item.time_ms;
          end
        end
        PH_SUSPECT: begin
          if (!in_win) begin
            phase_next = PH_READY;
          end else if (elapsed > {{(TIME_W-CFG_W){1'b0}}, cfg.hold_ms}) begin
            phase_next = PH_WAIT;
          end
        end
        PH_WAIT: begin
          if (below_fall) begin
            phase_next = PH_DONE;
          end else if (elapsed > {{(TIME_W-CFG_W){1'b0}}, cfg.give_up_ms}) begin
            phase_next = PH_READY;
          end
        end
        PH_DONE: phase_next = PH_READY;
        default: phase_next = PH_READY;
      endcase
    end
    // jam handling overrides, dropping a shot that just completed
    if (item.force_ready) begin
      phase_next = PH_READY;
    end
  end

  // heat and result
  always_comb begin
    shot = !rebirth && (phase == PH_DONE);
    sum  = {{(ACC_W-HEAT_WIDTH){1'b0}}, heat_acc} +
           {{(ACC_W-HPS_W){1'b0}}, (shot ? cfg.heat_per_shot : {HPS_W{1'b0}})};
    if (rebirth) begin
      base = '0;
    end else if (sum > {{(ACC_W-HEAT_WIDTH){1'b0}}, HEAT_MAX}) begin
      base = HEAT_MAX;
    end else begin
      base = sum[HEAT_WIDTH-1:0];
    end
    base_ext = {{(CMP_W-HEAT_WIDTH){1'b0}}, base};
    drop_ext = {{(CMP_W-DROP_W){1'b0}}, drop};
    if (drop_ext >= base_ext) begin
      heat_ext = '0;
    end else begin
      heat_ext = base_ext - drop_ext;
    end
    heat_acc_next = heat_ext[HEAT_WIDTH-1:0];

    if (heat_ext > {{(CMP_W-OUT_HEAT_W){1'b0}}, {OUT_HEAT_W{1'b1}}}) begin
      res.heat = '1;
    end else begin
      res.heat = heat_ext[OUT_HEAT_W-1:0];
    end
    res.shot_counted = shot;
    res.detect_phase = phase_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_READY;
      suspect_start  <= '0;
      heat_acc       <= '0;
      hp_was_nonzero <= 1'b0;
    end else if (en) begin
      phase          <= phase_next;
      suspect_start  <= suspect_start_next;
      heat_acc       <= heat_acc_next;
      hp_was_nonzero <= (item.robot_hp != '0);
    end
  end

endmodule

// ===== rtl/shot_detect_heat_estimator_top.sv =====
// Top level of the shot detect / heat estimator: input pipeline, cooling
// multiply and output register. Depends on shd_pkg, shd_cfg_regs, shd_track.
//
// Usage:
//   Input channel in_valid/in_ready/in_item carries one control tick per item.
//   Output channel out_valid/out_ready/out_item returns exactly one result
//   (heat, shot flag, detector phase after the tick) per input item, in order.
//   The APB-style port sets window, fall level, hold and give-up times and the
//   heat per shot; write it only while no item is in flight.
//   The item is registered in the input stage at the edge that accepts it, then
//   passes the cooling multiply stage and the result register, which drives out_valid.
//   Throughput: one item per cycle while out_ready stays high; the detector and
//   heat update close on the stage that holds the state, the 16x32 cooling
//   product being registered one stage earlier.
//   When the receiver stalls, the stages fill and in_ready drops once all three
//   hold items; no item is lost. in_ready follows out_ready combinationally.
//   Reset (rst, synchronous) empties the pipeline, returns the registers to
//   their defaults, clears heat and phase, and marks the next tick as the
//   first one (zero elapsed time).
`include "shot_detect_heat_estimator_top_macros.svh"
module shot_detect_heat_estimator_top #(
  parameter int HEAT_WIDTH = shd_pkg::HEAT_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  shd_pkg::in_item_t            in_item,
  output logic                         out_valid,
  input  logic                         out_ready,
  output shd_pkg::out_item_t           out_item,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [shd_pkg::PADDR_W-1:0]  paddr,
  input  logic [shd_pkg::PDATA_W-1:0]  pwdata,
  output logic [shd_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);
  import shd_pkg::*;

  cfg_t              cfg;
  logic              accept;
  logic              time_valid;
  logic [TIME_W-1:0] prev_time;
  logic [TIME_W-1:0] dt_in;

  logic              s1_valid, s2_valid;
  in_item_t          s1_item, s2_item;
  logic [TIME_W-1:0] s1_dt;
  logic [DROP_W-1:0] s2_drop;
  logic              s1_en, s2_en, out_en, s2_move;
  out_item_t         res;

  shd_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign out_en   = !out_valid || out_ready;
  assign s2_en    = !s2_valid || out_en;
  assign s1_en    = !s1_valid || s2_en;
  assign s2_move  = s2_valid && out_en;
  assign in_ready = s1_en;
  assign accept   = in_valid && in_ready;

  // elapsed time is known at acceptance; the first tick after reset sees zero
  assign dt_in = time_valid ? (in_item.time_ms - prev_time) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_valid <= 1'b0;
      prev_time  <= '0;
    end else if (accept) begin
      time_valid <= 1'b1;
      prev_time  <= in_item.time_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_valid <= in_valid;
      end
      if (s2_en) begin
        s2_valid <= s1_valid;
      end
      if (out_en) begin
        out_valid <= s2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= in_item;
      s1_dt   <= dt_in;
    end
    if (s2_en && s1_valid) begin
      s2_item <= s1_item;
      s2_drop <= DROP_W'(s1_item.cooling_rate) * DROP_W'(s1_dt);
    end
    if (s2_move) begin
      out_item <= res;
    end
  end

  shd_track #(
    .HEAT_WIDTH (HEAT_WIDTH)
  ) u_track (
    .clk  (clk),
    .rst  (rst),
    .en   (s2_move),
    .cfg  (cfg),
    .item (s2_item),
    .drop (s2_drop),
    .res  (res)
  );

  `SHD_ASSERT(a_shot_leaves_ready, out_valid && out_item.shot_counted |-> out_item.detect_phase == PH_READY)
  `SHD_ASSERT(a_full_backpressure, s1_valid && s2_valid && out_valid && !out_ready |-> !in_ready)
  `SHD_ASSERT_RST(a_reset_empties, rst |=> !s1_valid && !s2_valid && !out_valid)

endmodule
